// File: design/baaf_pkg.sv
// Shared types, widths and constants of the band air attenuation factor unit.
// Holds the root constant generator used to build the exponent pipeline.
// No dependencies.
package baaf_pkg;

   localparam int unsigned MAX_BANDS         = 8;
   localparam int unsigned NUM_BANDS_DEFAULT = 8;
   localparam int unsigned REG_COUNT         = 8;
   localparam int unsigned BAND_WIDTH        = 3;
   localparam int unsigned CSR_INDEX_WIDTH   = 4;
   localparam int unsigned COEF_WIDTH        = 20;
   localparam int unsigned BAND_IN_WIDTH     = 8;
   localparam int unsigned DIST_IN_WIDTH     = 24;
   localparam int unsigned DIST_WIDTH        = 23;
   localparam int unsigned FACTOR_WIDTH      = 17;

   localparam int unsigned PROD_WIDTH        = COEF_WIDTH + DIST_WIDTH;
   localparam int unsigned P16_SHIFT         = 12;
   localparam int unsigned P16_WIDTH         = PROD_WIDTH - P16_SHIFT;
   localparam int unsigned LOG_CONST_WIDTH   = 30;
   localparam logic [LOG_CONST_WIDTH-1:0] LOG2_10_OVER_20 = 30'd713378626;
   localparam int unsigned EXP_PROD_WIDTH    = P16_WIDTH + LOG_CONST_WIDTH;
   localparam int unsigned EXP_SHIFT         = 24;
   localparam int unsigned FRAC_WIDTH        = 24;
   localparam int unsigned INT_WIDTH         = EXP_PROD_WIDTH - EXP_SHIFT - FRAC_WIDTH;
   localparam int unsigned SHIFT_WIDTH       = 5;
   localparam int unsigned ZERO_EXP          = 17;

   localparam int unsigned ROOT_STEPS        = 24;
   localparam int unsigned ROOT_WIDTH        = 30;
   localparam int unsigned M_WIDTH           = 31;
   localparam int unsigned ROOT_PROD_WIDTH   = M_WIDTH + ROOT_WIDTH;
   localparam logic [M_WIDTH-1:0] M_ONE      = 31'h4000_0000;
   localparam int unsigned ROUND_BASE        = 13;
   localparam int unsigned FINAL_WIDTH       = 32;

   // accept edge to strobe: issue, product, exponent, roots, output
   localparam int unsigned LATENCY           = ROOT_STEPS + 4;

   localparam logic KIND_ONE_BAND  = 1'b0;
   localparam logic KIND_ALL_BANDS = 1'b1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_BAND0 = 4'd0,
      CSR_COEF_BAND1 = 4'd1,
      CSR_COEF_BAND2 = 4'd2,
      CSR_COEF_BAND3 = 4'd3,
      CSR_COEF_BAND4 = 4'd4,
      CSR_COEF_BAND5 = 4'd5,
      CSR_COEF_BAND6 = 4'd6,
      CSR_COEF_BAND7 = 4'd7
   } csr_index_type;

   localparam logic [COEF_WIDTH-1:0] COEF_RESET [REG_COUNT] = '{
      20'd0, 20'd419, 20'd1049, 20'd2621, 20'd5243, 20'd15729, 20'd52429, 20'd157286
   };

   typedef struct packed {
      logic                             kind;
      logic signed [BAND_IN_WIDTH-1:0] band_index;
      logic signed [DIST_IN_WIDTH-1:0] distance;
   } req_word_type;

   typedef struct packed {
      logic [BAND_WIDTH-1:0]   result_band;
      logic [FACTOR_WIDTH-1:0] amplitude_factor;
      logic                    last;
   } rsp_word_type;

   typedef struct packed {
      logic [BAND_WIDTH-1:0] band;
      logic                  last;
   } tag_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_w;
      v     = value;
      res   = '0;
      bit_w = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bit_w) begin
            v   = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // r(1) = isqrt(2^59), r(k+1) = isqrt(r(k) << 30): 2^(-2^-k) in Q.30
   function automatic logic [ROOT_WIDTH-1:0] root_const(input int unsigned k);
      logic [63:0] r;
      r = isqrt64(64'd1 << 59);
      for (int unsigned i = 1; i < k; i++) begin
         r = isqrt64(r << 30);
      end
      return r[ROOT_WIDTH-1:0];
   endfunction

endpackage

// File: design/band_air_attenuation_factor_unit.sv
// Band air attenuation factor unit: dB-per-metre coefficients to linear gain.
// Depends on baaf_pkg; fully pipelined, one result word per cycle.
//
//   channel  ports                       direction  handshake
//   request  start, busy, req_word       in         taken when start && !busy
//   result   rsp_valid, rsp_word         out        one-cycle strobe, no stall
//   config   csr_we, csr_index, csr_wdata in        written when csr_we and csr_index <= 7
//
// A result word passes the issue, product, exponent, root and output registers in turn.
// A one-band request issues a single word; an all-bands request issues NUM_BANDS
// words through the issue sequencer, which feeds one band per cycle.
// Reset clears the valid bits, the sequencer and loads the coefficient defaults.
// The result side cannot stall, so the pipeline never holds.
module band_air_attenuation_factor_unit
   import baaf_pkg::*;
#(
   parameter int unsigned NUM_BANDS = NUM_BANDS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_word_type               req_word,
   output logic                       rsp_valid,
   output rsp_word_type               rsp_word,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   localparam logic [BAND_WIDTH-1:0]    LAST_BAND    = BAND_WIDTH'(NUM_BANDS - 1);
   localparam logic [BAND_IN_WIDTH-1:0] LAST_BAND_IN = BAND_IN_WIDTH'(NUM_BANDS - 1);

   logic [COEF_WIDTH-1:0] coef_ff [REG_COUNT];

   logic                  seq_active_ff, seq_active_in;
   logic [BAND_WIDTH-1:0] seq_band_ff, seq_band_in;
   logic [DIST_WIDTH-1:0] seq_dist_ff, seq_dist_in;

   logic                  accept;
   logic [DIST_WIDTH-1:0] dist_clamped;
   logic [BAND_WIDTH-1:0] band_clamped;
   logic                  issue_valid;
   tag_type               issue_tag;
   logic [DIST_WIDTH-1:0] issue_dist;

   logic                  vld0_ff, vld1_ff;
   tag_type               tag0_ff, tag1_ff;
   logic [COEF_WIDTH-1:0] coef0_ff;
   logic [DIST_WIDTH-1:0] dist0_ff;
   logic [PROD_WIDTH-1:0] prod;
   logic [P16_WIDTH-1:0]  p16_ff;

   logic [EXP_PROD_WIDTH-1:0] exp_prod;
   logic [INT_WIDTH-1:0]      exp_int;

   logic                   vld_ff  [ROOT_STEPS+1];
   tag_type                tag_ff  [ROOT_STEPS+1];
   logic [FRAC_WIDTH-1:0]  f_ff    [ROOT_STEPS+1];
   logic [SHIFT_WIDTH-1:0] n_ff    [ROOT_STEPS+1];
   logic                   zero_ff [ROOT_STEPS+1];
   logic [M_WIDTH-1:0]     m_ff    [ROOT_STEPS+1];
   logic [M_WIDTH-1:0]     m_in    [ROOT_STEPS+1];

   logic [SHIFT_WIDTH-1:0] rnd_shift;
   logic [SHIFT_WIDTH-1:0] out_shift;
   logic [FINAL_WIDTH-1:0] rounded;
   logic [FINAL_WIDTH-1:0] shifted;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   assign busy   = seq_active_ff;
   assign accept = start && !busy;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_we && csr_index <= CSR_INDEX_WIDTH'(CSR_COEF_BAND7)) begin
         coef_ff[csr_index[BAND_WIDTH-1:0]] <= csr_wdata;
      end
   end

   // request decode and issue sequencer
   assign dist_clamped = req_word.distance[DIST_IN_WIDTH-1] ? '0
                                                            : req_word.distance[DIST_WIDTH-1:0];

   always_comb begin
      priority if (req_word.band_index[BAND_IN_WIDTH-1]) begin
         band_clamped = '0;
      end else if ($unsigned(req_word.band_index) > LAST_BAND_IN) begin
         band_clamped = LAST_BAND;
      end else begin
         band_clamped = req_word.band_index[BAND_WIDTH-1:0];
      end
   end

   always_comb begin
      issue_valid   = 1'b0;
      issue_tag     = '0;
      issue_dist    = seq_dist_ff;
      seq_active_in = seq_active_ff;
      seq_band_in   = seq_band_ff;
      seq_dist_in   = seq_dist_ff;
      priority if (seq_active_ff) begin
         issue_valid    = 1'b1;
         issue_tag.band = seq_band_ff;
         issue_tag.last = (seq_band_ff == LAST_BAND);
         seq_active_in  = (seq_band_ff != LAST_BAND);
         seq_band_in    = seq_band_ff + BAND_WIDTH'(1);
      end else if (accept) begin
         issue_valid = 1'b1;
         issue_dist  = dist_clamped;
         if (req_word.kind == KIND_ALL_BANDS) begin
            issue_tag.band = '0;
            issue_tag.last = (LAST_BAND == '0);
            seq_active_in  = (LAST_BAND != '0);
            seq_band_in    = BAND_WIDTH'(1);
            seq_dist_in    = dist_clamped;
         end else begin
            issue_tag.band = band_clamped;
            issue_tag.last = 1'b1;
         end
      end
   end

   // exponent front end: coefficient times distance, then times log2(10)/20
   assign prod     = PROD_WIDTH'(coef0_ff) * PROD_WIDTH'(dist0_ff);
   assign exp_prod = EXP_PROD_WIDTH'(p16_ff) * EXP_PROD_WIDTH'(LOG2_10_OVER_20);
   assign exp_int  = exp_prod[EXP_PROD_WIDTH-1:EXP_SHIFT+FRAC_WIDTH];

   // one root multiply per stage, fraction bits taken most significant first
   assign m_in[0] = M_ONE;
   for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
      localparam logic [ROOT_WIDTH-1:0] ROOT = root_const(j);
      logic [ROOT_PROD_WIDTH-1:0] root_prod;
      assign root_prod = ROOT_PROD_WIDTH'(m_ff[j-1]) * ROOT_PROD_WIDTH'(ROOT);
      assign m_in[j]   = f_ff[j-1][ROOT_STEPS-j] ? root_prod[ROOT_PROD_WIDTH-1:ROOT_WIDTH]
                                                 : m_ff[j-1];
   end

   // round half up and scale by the integer part of the exponent
   assign rnd_shift = SHIFT_WIDTH'(ROUND_BASE) + n_ff[ROOT_STEPS];
   assign out_shift = rnd_shift + SHIFT_WIDTH'(1);
   assign rounded   = FINAL_WIDTH'(m_ff[ROOT_STEPS]) + (FINAL_WIDTH'(1) << rnd_shift);
   assign shifted   = rounded >> out_shift;

   always_comb begin
      rsp_word_in.result_band      = tag_ff[ROOT_STEPS].band;
      rsp_word_in.last             = tag_ff[ROOT_STEPS].last;
      rsp_word_in.amplitude_factor = zero_ff[ROOT_STEPS] ? '0 : shifted[FACTOR_WIDTH-1:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
         seq_band_ff   <= '0;
         vld0_ff       <= 1'b0;
         vld1_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i <= ROOT_STEPS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         seq_active_ff <= seq_active_in;
         seq_band_ff   <= seq_band_in;
         vld0_ff       <= issue_valid;
         vld1_ff       <= vld0_ff;
         vld_ff[0]     <= vld1_ff;
         for (int i = 1; i <= ROOT_STEPS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff  <= vld_ff[ROOT_STEPS];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      seq_dist_ff <= seq_dist_in;
      tag0_ff     <= issue_tag;
      coef0_ff    <= coef_ff[issue_tag.band];
      dist0_ff    <= issue_dist;
      tag1_ff     <= tag0_ff;
      p16_ff      <= prod[PROD_WIDTH-1:P16_SHIFT];
      tag_ff[0]   <= tag1_ff;
      f_ff[0]     <= exp_prod[EXP_SHIFT+FRAC_WIDTH-1:EXP_SHIFT];
      n_ff[0]     <= exp_int[SHIFT_WIDTH-1:0];
      zero_ff[0]  <= (exp_int >= INT_WIDTH'(ZERO_EXP));
      m_ff[0]     <= m_in[0];
      for (int i = 1; i <= ROOT_STEPS; i++) begin
         tag_ff[i]  <= tag_ff[i-1];
         f_ff[i]    <= f_ff[i-1];
         n_ff[i]    <= n_ff[i-1];
         zero_ff[i] <= zero_ff[i-1];
         m_ff[i]    <= m_in[i];
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: design/baaf_checker.sv
// Port-level checks of the band air attenuation factor unit, bound to its top level.
// Depends on baaf_pkg.
module baaf_checker
   import baaf_pkg::*;
#(
   parameter int unsigned NUM_BANDS = NUM_BANDS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);

   // drop all activity after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity right after reset");

   // a taken word comes out after the fixed pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("result word missing at pipeline latency");

   // an all-bands burst has no gaps and counts bands upward
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |=>
         rsp_valid && rsp_word.result_band == BAND_WIDTH'($past(rsp_word.result_band) + 1))
      else $error("all-bands burst broken");

   // hold off new words while an all-bands request is still issuing
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (NUM_BANDS > 1) && start && !busy && req_word.kind == KIND_ALL_BANDS |=> busy)
      else $error("busy missing after all-bands request");

endmodule

bind band_air_attenuation_factor_unit baaf_checker #(.NUM_BANDS(NUM_BANDS)) u_baaf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

// File: tb/band_air_attenuation_factor_unit_tb.sv
// Testbench for band_air_attenuation_factor_unit: directed and random requests,
// with a bit-exact gain predictor and an in-order result scoreboard.
// Depends on baaf_pkg and the unit itself.
`timescale 1ns / 100ps

module band_air_attenuation_factor_unit_tb;
   import baaf_pkg::*;

   localparam int unsigned BANDS       = NUM_BANDS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned ROOT_COUNT  = 24;

   typedef enum int {COEF_ALL_MAX, COEF_RANDOM, COEF_SCALED, COEF_ALTERNATE} coef_plan_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   req_word_type               req_word = '0;
   logic                       rsp_valid;
   rsp_word_type               rsp_word;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0]      csr_wdata = '0;

   req_word_type          pending_words [$];
   rsp_word_type          expected_factors [$];
   logic [COEF_WIDTH-1:0] coef_copy [REG_COUNT];
   logic [63:0]           half_root [1:ROOT_COUNT];
   logic                  word_taken = 1'b0;
   int unsigned           sender_idle_pct = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           cycle_count = 0;

   band_air_attenuation_factor_unit #(
      .NUM_BANDS(BANDS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic logic [FACTOR_WIDTH-1:0] gain_for(input logic [COEF_WIDTH-1:0] coef,
                                                        input logic [DIST_WIDTH-1:0] dist_val);
      logic [63:0] product;
      logic [63:0] db_q16;
      logic [63:0] expo;
      logic [63:0] whole;
      logic [23:0] frac;
      logic [63:0] mant;
      product = 64'(coef) * 64'(dist_val);
      db_q16  = product >> 12;
      expo    = (db_q16 * 64'(LOG2_10_OVER_20)) >> 24;
      whole   = expo >> 24;
      frac    = expo[23:0];
      mant    = 64'd1 << 30;
      if (whole >= ZERO_EXP) return '0;
      for (int k = 1; k <= ROOT_COUNT; k++) begin
         if (frac[ROOT_COUNT-k]) mant = (mant * half_root[k]) >> 30;
      end
      return FACTOR_WIDTH'((mant + (64'd1 << (13 + whole))) >> (14 + whole));
   endfunction

   function automatic void predict_factors(input req_word_type w);
      logic [DIST_WIDTH-1:0] dist_val;
      rsp_word_type          r;
      int                    band_req;
      dist_val = w.distance[DIST_IN_WIDTH-1] ? '0 : w.distance[DIST_WIDTH-1:0];
      if (w.kind == KIND_ONE_BAND) begin
         band_req = int'(w.band_index);
         if (band_req < 0) band_req = 0;
         else if (band_req > int'(BANDS) - 1) band_req = int'(BANDS) - 1;
         r.result_band      = BAND_WIDTH'(band_req);
         r.amplitude_factor = gain_for(coef_copy[band_req], dist_val);
         r.last             = 1'b1;
         expected_factors.push_back(r);
      end else begin
         for (int b = 0; b < int'(BANDS); b++) begin
            r.result_band      = BAND_WIDTH'(b);
            r.amplitude_factor = gain_for(coef_copy[b], dist_val);
            r.last             = (b == int'(BANDS) - 1);
            expected_factors.push_back(r);
         end
      end
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : accept_sampler
      word_taken <= !reset && start && !busy;
   end

   always @(negedge clock) begin : req_driver
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (word_taken) predict_factors(pending_words.pop_front());
         if (!start || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               start    <= 1'b1;
               req_word <= pending_words[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_factors.size() == 0) begin
            flag_mismatch("unexpected word, band", rsp_word.result_band, 0);
         end else begin
            want = expected_factors.pop_front();
            if (rsp_word.result_band != want.result_band)
               flag_mismatch("result_band", rsp_word.result_band, want.result_band);
            if (rsp_word.amplitude_factor != want.amplitude_factor)
               flag_mismatch("amplitude_factor", rsp_word.amplitude_factor,
                             want.amplitude_factor);
            if (rsp_word.last != want.last)
               flag_mismatch("last", rsp_word.last, want.last);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_word(input logic kind, input int band, input int dist_val);
      req_word_type w;
      w.kind       = kind;
      w.band_index = band[BAND_IN_WIDTH-1:0];
      w.distance   = dist_val[DIST_IN_WIDTH-1:0];
      pending_words.push_back(w);
   endtask

   task automatic add_random_word();
      req_word_type w;
      int unsigned  bits;
      w.kind = ($urandom_range(0, 99) < 40) ? KIND_ALL_BANDS : KIND_ONE_BAND;
      w.band_index = ($urandom_range(0, 99) < 60) ? BAND_IN_WIDTH'($urandom_range(0, BANDS - 1))
                                                   : BAND_IN_WIDTH'($urandom);
      case ($urandom_range(0, 9))
         0, 1: w.distance = DIST_IN_WIDTH'($urandom);
         2: w.distance = {1'b1, DIST_WIDTH'($urandom)};
         default: begin
            bits = $urandom_range(1, DIST_WIDTH);
            w.distance = {1'b0, DIST_WIDTH'($urandom & ((32'd1 << bits) - 1))};
         end
      endcase
      pending_words.push_back(w);
   endtask

   task automatic write_coef(input logic [CSR_INDEX_WIDTH-1:0] idx,
                             input logic [COEF_WIDTH-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < REG_COUNT) coef_copy[idx] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_coefs(input coef_plan_type plan);
      logic [COEF_WIDTH-1:0] value;
      for (int i = 0; i < int'(REG_COUNT); i++) begin
         case (plan)
            COEF_ALL_MAX: value = '1;
            COEF_RANDOM: value = COEF_WIDTH'($urandom);
            COEF_SCALED: value = COEF_WIDTH'($urandom & ((32'd1 << $urandom_range(1, 20)) - 1));
            default: value = (i % 2 == 1) ? '1 : '0;
         endcase
         write_coef(csr_index_type'(i), value);
      end
      write_coef(CSR_INDEX_WIDTH'(REG_COUNT + $urandom_range(0, 7)), COEF_WIDTH'($urandom));
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_words.size() != 0 || start || expected_factors.size() != 0);
   endtask

   initial begin : stimulus
      int unsigned   idle_plan [4];
      coef_plan_type coef_plan [4];
      idle_plan = '{0, 83, 0, 38};
      coef_plan = '{COEF_ALL_MAX, COEF_RANDOM, COEF_SCALED, COEF_ALTERNATE};
      for (int k = 1; k <= int'(ROOT_COUNT); k++)
         half_root[k] = (k == 1) ? floor_sqrt(64'd1 << 59) : floor_sqrt(half_root[k-1] << 30);
      for (int i = 0; i < int'(REG_COUNT); i++) coef_copy[i] = COEF_RESET[i];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_word(KIND_ONE_BAND, 0, 0);
      add_word(KIND_ONE_BAND, 3, 256);
      add_word(KIND_ONE_BAND, 7, 8388607);
      add_word(KIND_ONE_BAND, -128, 1000);
      add_word(KIND_ONE_BAND, -1, 5000);
      add_word(KIND_ONE_BAND, 8, 100000);
      add_word(KIND_ONE_BAND, 127, 2560);
      add_word(KIND_ONE_BAND, 2, -1);
      add_word(KIND_ONE_BAND, 5, -8388608);
      add_word(KIND_ONE_BAND, 6, 1);
      add_word(KIND_ONE_BAND, 1, 65535);
      add_word(KIND_ALL_BANDS, 0, 0);
      add_word(KIND_ALL_BANDS, 99, 25600);
      add_word(KIND_ALL_BANDS, -77, -300);
      add_word(KIND_ALL_BANDS, 0, 8388607);
      add_word(KIND_ALL_BANDS, 4, 2000000);
      add_word(KIND_ALL_BANDS, -128, 1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         load_coefs(coef_plan[p]);
         sender_idle_pct = idle_plan[p];
         repeat (25) add_random_word();
         wait_drained();
      end

      repeat (LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
